/* rtl/core/fge_pkg.sv */
// fge_pkg: shared codes and constants of the fire grid evolve core.
// No dependencies; imported by the core and its checker.
`default_nettype none
package fge_pkg;

    localparam logic [1:0] CMD_SEED   = 2'd0;
    localparam logic [1:0] CMD_EVOLVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PASSIVE = 2'd1;
    localparam logic [1:0] MODE_SPARK   = 2'd2;
    localparam logic [1:0] MODE_TEMP    = 2'd3;

    localparam logic [2:0] REG_SPARK_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_HORIZONTAL_GAIN = 3'd1;
    localparam logic [2:0] REG_VERTICAL_GAIN   = 3'd2;
    localparam logic [2:0] REG_PASSIVE_KEEP    = 3'd3;
    localparam logic [2:0] REG_SPARK_TRANSFER  = 3'd4;
    localparam logic [2:0] REG_SPARK_KEEP      = 3'd5;

    localparam logic [7:0] SOURCE_BASE = 8'd100;
    localparam logic [7:0] SPARK_BASE  = 8'd200;
    localparam logic [7:0] E_MAX       = 8'd255;

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? E_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/fire_grid_evolve_core.sv */
// fire_grid_evolve_core: fire-effect cell grid held in energy and mode RAMs.
// Depends on fge_pkg and fge_ram.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser command, s_tdata coordinates and draws
// m_       out  m_tvalid/m_tready  m_tuser reply kind, m_tdata cell energy and mode
// cfg_     in   cfg_valid/ready    cfg_index, cfg_data (ready while idle)
//
// One command at a time; the result sits in an output register, so the next
// command is taken while it waits. Evolve walks cells through one RAM read port
// in states EV_C, EV_B, EV_L, EV_R, EV_CALC, EV_WR, plus EV_NB if a neighbor mode
// is written. Seed uses SD_WR, SD_CHK; read RD_ADDR, RD_DATA; clear CLR per cell.
// After reset a clearing pass over all W*H cells runs with s_tready low.
`default_nettype none
module fire_grid_evolve_core
    import fge_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    input  wire logic [31:0] s_tdata,   // [3:0] column, [7:4] row, [14:8] source_draw,
                                        // [22:15] spark_draw, [28:23] spark_energy_draw
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_tuser,   // [1:0] reply_kind
    output logic [15:0]      m_tdata,   // [7:0] cell_energy, [9:8] cell_mode
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam logic [AW-1:0] W_A    = AW'(GRID_WIDTH);
    localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_SD_WR, ST_SD_CHK, ST_RD_ADDR, ST_RD_DATA,
        ST_EV_C, ST_EV_B, ST_EV_L, ST_EV_R, ST_EV_CALC, ST_EV_WR, ST_EV_NB, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] thr_reg, hg_reg, vg_reg, pk_reg, st_reg, sk_reg;
    logic [1:0] cmd_reg;
    logic [3:0] col_reg, row_reg;
    logic [6:0] src_reg;
    logic [7:0] sdraw_reg;
    logic [5:0] sen_reg;

    logic [AW-1:0] c_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [7:0]  e_reg, below_reg, left_reg;
    logic [1:0]  m_reg;
    logic [7:0]  dlr_reg, db_reg, ek_reg, et_reg;
    logic        blt_reg;
    logic [AW-1:0] nb_addr_reg;
    logic [1:0]  nb_mode_reg;

    logic [7:0]  res_e_reg;
    logic [1:0]  res_m_reg;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_e_reg;
    logic [1:0]  out_m_reg;

    logic          e_we, m_we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    e_wdata, e_rdata;
    logic [1:0]    m_wdata, m_rdata;

    logic          s_fire;
    logic          col_ok, row_ok;
    logic [AW-1:0] read_addr;
    logic [8:0]    lr_sum;
    logic [16:0]   h_prod;
    logic [15:0]   v_prod, k_prod, t_prod;
    logic [7:0]    t_sum;
    logic          y_top, y_bot;
    logic [7:0]    new_e;
    logic [1:0]    new_m;
    logic          new_nb_we;
    logic [AW-1:0] new_nb_addr;
    logic [1:0]    new_nb_mode;

    fge_ram #(.WIDTH(8), .DEPTH(CELLS)) u_energy (
        .aclk(aclk), .we(e_we), .waddr(waddr), .wdata(e_wdata),
        .raddr(raddr), .rdata(e_rdata)
    );
    fge_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mode (
        .aclk(aclk), .we(m_we), .waddr(waddr), .wdata(m_wdata),
        .raddr(raddr), .rdata(m_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tdata   = {6'd0, out_m_reg, out_e_reg};

    assign col_ok    = (32'(col_reg) < GRID_WIDTH);
    assign row_ok    = (32'(row_reg) < GRID_HEIGHT);
    assign read_addr = AW'(32'(row_reg) * GRID_WIDTH + 32'(col_reg));
    assign y_bot     = (y_reg == '0);
    assign y_top     = (y_reg == Y_LAST);

    assign lr_sum = {1'b0, left_reg} + {1'b0, e_rdata};
    assign h_prod = lr_sum * hg_reg;
    assign v_prod = below_reg * vg_reg;
    assign k_prod = e_reg * pk_reg;
    assign t_sum  = sat_add8(e_reg, below_reg);
    assign t_prod = t_sum * sk_reg;

    always_comb begin
        new_e       = e_reg;
        new_m       = m_reg;
        new_nb_we   = 1'b0;
        new_nb_addr = c_reg + W_A;
        new_nb_mode = MODE_TEMP;
        case (m_reg)
            MODE_PASSIVE: begin
                if (!y_bot) begin
                    new_e = sat_add8(sat_add8(ek_reg, dlr_reg), db_reg);
                end
            end
            MODE_SPARK: begin
                new_e = sat_sub8(e_reg, st_reg);
                if (y_top) begin
                    new_m = MODE_PASSIVE;
                end else begin
                    new_nb_we = 1'b1;
                end
            end
            MODE_TEMP: begin
                if (!y_bot) begin
                    if (blt_reg) begin
                        new_e       = et_reg;
                        new_m       = MODE_SPARK;
                        new_nb_we   = 1'b1;
                        new_nb_addr = c_reg - W_A;
                        new_nb_mode = MODE_PASSIVE;
                    end else begin
                        new_e = sat_add8(e_reg, st_reg);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        e_we    = 1'b0;
        m_we    = 1'b0;
        waddr   = c_reg;
        e_wdata = 8'd0;
        m_wdata = MODE_NONE;
        raddr   = c_reg;
        unique case (state_reg)
            ST_CLR: begin
                e_we = 1'b1;
                m_we = 1'b1;
                if (c_reg == LAST_A) begin
                    state_next = (cmd_reg == CMD_CLEAR) ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_tuser)
                        CMD_SEED:   state_next = ST_SD_WR;
                        CMD_EVOLVE: state_next = ST_EV_C;
                        CMD_READ:   state_next = ST_RD_ADDR;
                        default:    state_next = ST_CLR;
                    endcase
                end
            end
            ST_SD_WR: begin
                waddr   = AW'(col_reg);
                raddr   = AW'(col_reg) + W_A;
                e_wdata = SOURCE_BASE + 8'(src_reg);
                if (col_ok) begin
                    e_we = 1'b1;
                    m_we = 1'b1;
                    state_next = (GRID_HEIGHT > 1) ? ST_SD_CHK : ST_DONE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SD_CHK: begin
                waddr   = AW'(col_reg) + W_A;
                e_wdata = sat_add8(SPARK_BASE, 8'(sen_reg));
                m_wdata = MODE_SPARK;
                if (m_rdata != MODE_SPARK && sdraw_reg <= thr_reg) begin
                    e_we = 1'b1;
                    m_we = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_RD_ADDR: begin
                raddr = read_addr;
                state_next = (col_ok && row_ok) ? ST_RD_DATA : ST_DONE;
            end
            ST_RD_DATA: begin
                state_next = ST_DONE;
            end
            ST_EV_C: begin
                raddr = c_reg;
                state_next = ST_EV_B;
            end
            ST_EV_B: begin
                raddr = c_reg - W_A;
                state_next = ST_EV_L;
            end
            ST_EV_L: begin
                raddr = (x_reg == '0) ? (c_reg + W_A - AW'(1)) : (c_reg - AW'(1));
                state_next = ST_EV_R;
            end
            ST_EV_R: begin
                raddr = (x_reg == X_LAST) ? (c_reg - W_A + AW'(1)) : (c_reg + AW'(1));
                state_next = ST_EV_CALC;
            end
            ST_EV_CALC: begin
                state_next = ST_EV_WR;
            end
            ST_EV_WR: begin
                e_we    = 1'b1;
                m_we    = 1'b1;
                e_wdata = new_e;
                m_wdata = new_m;
                if (new_nb_we) begin
                    state_next = ST_EV_NB;
                end else begin
                    state_next = (c_reg == LAST_A) ? ST_DONE : ST_EV_C;
                end
            end
            ST_EV_NB: begin
                m_we    = 1'b1;
                waddr   = nb_addr_reg;
                m_wdata = nb_mode_reg;
                state_next = (c_reg == LAST_A) ? ST_DONE : ST_EV_C;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            c_reg         <= '0;
            cmd_reg       <= CMD_SEED;
            out_valid_reg <= 1'b0;
            thr_reg <= 8'd4;
            hg_reg  <= 8'd35;
            vg_reg  <= 8'd40;
            pk_reg  <= 8'd120;
            st_reg  <= 8'd40;
            sk_reg  <= 8'd200;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPARK_THRESHOLD: thr_reg <= cfg_data;
                    REG_HORIZONTAL_GAIN: hg_reg  <= cfg_data;
                    REG_VERTICAL_GAIN:   vg_reg  <= cfg_data;
                    REG_PASSIVE_KEEP:    pk_reg  <= cfg_data;
                    REG_SPARK_TRANSFER:  st_reg  <= cfg_data;
                    REG_SPARK_KEEP:      sk_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_valid_reg && m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR: begin
                    c_reg <= c_reg + AW'(1);
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        cmd_reg   <= s_tuser;
                        col_reg   <= s_tdata[3:0];
                        row_reg   <= s_tdata[7:4];
                        src_reg   <= s_tdata[14:8];
                        sdraw_reg <= s_tdata[22:15];
                        sen_reg   <= s_tdata[28:23];
                        res_e_reg <= 8'd0;
                        res_m_reg <= MODE_NONE;
                        c_reg <= '0;
                        x_reg <= '0;
                        y_reg <= '0;
                    end
                end
                ST_RD_DATA: begin
                    res_e_reg <= e_rdata;
                    res_m_reg <= m_rdata;
                end
                ST_EV_B: begin
                    e_reg <= e_rdata;
                    m_reg <= m_rdata;
                end
                ST_EV_L: begin
                    below_reg <= e_rdata;
                end
                ST_EV_R: begin
                    left_reg <= e_rdata;
                end
                ST_EV_CALC: begin
                    dlr_reg <= h_prod[16:9];
                    db_reg  <= v_prod[15:8];
                    ek_reg  <= k_prod[15:8];
                    et_reg  <= t_prod[15:8];
                    blt_reg <= (st_reg > below_reg);
                end
                ST_EV_WR: begin
                    nb_addr_reg <= new_nb_addr;
                    nb_mode_reg <= new_nb_mode;
                    if (!new_nb_we) begin
                        c_reg <= c_reg + AW'(1);
                        if (x_reg == X_LAST) begin
                            x_reg <= '0;
                            y_reg <= y_reg + YW'(1);
                        end else begin
                            x_reg <= x_reg + XW'(1);
                        end
                    end
                end
                ST_EV_NB: begin
                    c_reg <= c_reg + AW'(1);
                    if (x_reg == X_LAST) begin
                        x_reg <= '0;
                        y_reg <= y_reg + YW'(1);
                    end else begin
                        x_reg <= x_reg + XW'(1);
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= cmd_reg;
                        out_e_reg     <= res_e_reg;
                        out_m_reg     <= res_m_reg;
                        cmd_reg       <= CMD_SEED;
                    end else begin
                        out_valid_reg <= out_valid_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/fge_ram.sv */
// fge_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/fge_checker.sv */
// fge_checker: port-level assertions for fire_grid_evolve_core, bound to it.
// Depends on fge_pkg.
`default_nettype none
module fge_checker
    import fge_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [1:0]  m_tuser,
    input wire logic [15:0] m_tdata
);
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ports active right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CMD_READ |-> m_tdata == 16'd0)
        else $error("non-read reply carries cell data");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a beat while a command is in progress");
endmodule

bind fire_grid_evolve_core fge_checker u_fge_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tuser(m_tuser), .m_tdata(m_tdata)
);
`default_nettype wire
